FILE: hdl/fccm_pkg.sv
// ----------------------------------------------------------------------------
// fccm_pkg
// Shared types and constants of the cluster chain manager: field widths,
// request and status codes, register indexes, table values and FSM states.
// ----------------------------------------------------------------------------
package fccm_pkg;

   // Table geometry default.
   localparam int FCCM_MAX_CLUSTERS = 4096;

   // Field widths.
   localparam int ENTRY_W  = 16;
   localparam int CT_W     = 13;
   localparam int BPC_W    = 17;
   localparam int MEDIA_W  = 8;
   localparam int LEN_W    = 32;
   localparam int IDX_W    = 16;
   localparam int USED_W   = 13;
   localparam int FUNC_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CAP_W    = 30;
   localparam int CMP_W    = 17;

   // Largest live count the cluster_total register can express.
   localparam int CT_MAX = (1 << CT_W) - 1;

   // Request kinds.
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_TOTAL     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_CLUSTER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIA_TYPE        = 2'd2;

   // Configuration reset values.
   localparam logic [CT_W-1:0]    CT_RESET    = 13'd4096;
   localparam logic [BPC_W-1:0]   BPC_RESET   = 17'd2048;
   localparam logic [MEDIA_W-1:0] MEDIA_RESET = 8'd248;

   // Table entry values.
   localparam logic [ENTRY_W-1:0] ENTRY_MEDIA_HI = 16'hFF00;
   localparam logic [ENTRY_W-1:0] ENTRY_EOC      = 16'hFFFF;
   localparam logic [ENTRY_W-1:0] ENTRY_FREE     = 16'h0000;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_BAD   = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_ALLOC,
      S_LINK_END,
      S_FREE_CHK,
      S_FREE_WR,
      S_READ,
      S_RESP
   } state_type;

endpackage

FILE: hdl/fccm_ram.sv
// ----------------------------------------------------------------------------
// fccm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module fccm_ram #(
   parameter int WIDTH = fccm_pkg::ENTRY_W,
   parameter int DEPTH = fccm_pkg::FCCM_MAX_CLUSTERS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/fat_cluster_chain_manager_top.sv
// A read answers from one table entry or a register; a free walks the chain and
// zeroes each cluster on it; an allocate scans the table twice (a capacity scan,
// then a link pass). One request is worked on at a time.
// The table RAM has a single read port.
// After reset a clearing pass writes every entry while req_tready stays low;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// fat_cluster_chain_manager_top
// FAT16-style allocation table with chain allocate, chain free and entry
// read requests. The table lives in one RAM; entries 0 and 1 are fixed and
// are produced from the media type register and a constant.
// ----------------------------------------------------------------------------
module fat_cluster_chain_manager_top #(
   parameter int MAX_CLUSTERS = fccm_pkg::FCCM_MAX_CLUSTERS
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [47:0]                     req_tdata,   // byte_length, cluster_index
   input  logic [fccm_pkg::FUNC_W-1:0]     req_tuser,   // func
   // Response channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // cluster_value, clusters_used, pad
   output logic [1:0]                      rsp_tuser,   // status
   // Configuration write channel.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fccm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fccm_pkg::BPC_W-1:0]      csr_wdata
);

   import fccm_pkg::*;

   localparam int AW     = $clog2(MAX_CLUSTERS);
   localparam int IW     = AW + 1;
   localparam int LIMCAP = (MAX_CLUSTERS < CT_MAX) ? MAX_CLUSTERS : CT_MAX;

   // Request fields.
   logic [FUNC_W-1:0] req_func;
   logic [LEN_W-1:0]  req_len;
   logic [IDX_W-1:0]  req_ci;

   assign req_func = req_tuser;
   assign req_len  = req_tdata[31:0];
   assign req_ci   = req_tdata[47:32];

   // Control and configuration registers.
   state_type          state_ff, state_in;
   logic [CT_W-1:0]    ct_ff, ct_in;
   logic [BPC_W-1:0]   bpc_ff, bpc_in;
   logic [MEDIA_W-1:0] media_ff, media_in;
   logic [IW-1:0]      ad_ff, ad_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [IDX_W-1:0]   start_ff, start_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [USED_W-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic [AW-1:0]      prev_ff, prev_in;
   logic [AW-1:0]      first_ff, first_in;
   status_type         res_status_ff, res_status_in;
   logic [ENTRY_W-1:0] res_value_ff, res_value_in;
   logic [USED_W-1:0]  res_used_ff, res_used_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0] rsp_value_ff, rsp_value_in;
   logic [USED_W-1:0]  rsp_used_ff, rsp_used_in;

   // Table RAM ports.
   logic               ram_we;
   logic [AW-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [AW-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rdata;

   // Derived conditions.
   logic [CT_W-1:0]    lim;
   logic [BPC_W-1:0]   bpc_eff;
   logic               req_fire;
   logic               csr_fire;
   logic               rsp_free;
   logic               ad_live;
   logic               scan_hit;
   logic               cap_ok;
   logic               scan_end;
   logic               take_last;
   logic               free_end;
   logic               free_bad;
   logic               ci_live;

   fccm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_CLUSTERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wdata),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rdata)
   );

   // Effective live count and cluster size.
   assign lim       = (ct_ff < CT_W'(LIMCAP)) ? ct_ff : CT_W'(LIMCAP);
   assign bpc_eff   = (bpc_ff == '0) ? BPC_W'(1) : bpc_ff;

   assign req_fire  = req_tvalid && req_tready;
   assign csr_fire  = csr_valid && csr_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // Scan and link pass conditions.
   assign ad_live   = CMP_W'(ad_ff) < CMP_W'(lim);
   assign scan_hit  = rd_vld_ff && (ram_rdata == ENTRY_FREE);
   assign cap_ok    = LEN_W'(cap_ff) >= len_ff;
   assign scan_end  = !ad_live && !rd_vld_ff;
   assign take_last = rem_ff <= LEN_W'(bpc_eff);

   // Chain walk conditions.
   assign free_end  = idx_ff == ENTRY_EOC;
   assign free_bad  = (idx_ff < IDX_W'(2)) || (idx_ff >= IDX_W'(lim)) || (cnt_ff >= lim);
   assign ci_live   = req_ci < IDX_W'(lim);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (ad_ff == IW'(MAX_CLUSTERS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_func)
                  FUNC_ALLOC: state_in = (req_len == '0) ? S_RESP : S_SCAN;
                  FUNC_FREE:  state_in = S_FREE_CHK;
                  FUNC_READ:  begin
                     state_in = (ci_live && req_ci >= IDX_W'(2)) ? S_READ : S_RESP;
                  end
                  default:    state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            priority if (cap_ok) state_in = S_ALLOC;
            else if (scan_end)   state_in = S_RESP;
         end
         S_ALLOC: begin
            if (scan_hit && take_last) state_in = S_LINK_END;
         end
         S_LINK_END: state_in = S_RESP;
         S_FREE_CHK: begin
            state_in = (free_end || free_bad) ? S_RESP : S_FREE_WR;
         end
         S_FREE_WR:  state_in = S_FREE_CHK;
         S_READ:     state_in = S_RESP;
         S_RESP: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath, table accesses and results.
   always_comb begin
      ad_in         = ad_ff;
      rd_vld_in     = 1'b0;
      len_in        = len_ff;
      rem_in        = rem_ff;
      cap_in        = cap_ff;
      start_in      = start_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      prev_in       = prev_ff;
      first_in      = first_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_used_in   = res_used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_used_in   = rsp_used_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = ad_ff[AW-1:0];
      ram_wdata     = ENTRY_FREE;
      ram_rd_addr   = ad_ff[AW-1:0];

      unique case (state_ff)
         // Zero one entry per cycle after reset.
         S_CLEAR: begin
            ram_we = 1'b1;
            ad_in  = ad_ff + IW'(1);
         end

         // Take a request and settle the cases that need no table walk.
         S_IDLE: begin
            ram_rd_addr = req_ci[AW-1:0];
            if (req_fire) begin
               len_in   = req_len;
               rem_in   = req_len;
               start_in = req_ci;
               idx_in   = req_ci;
               cnt_in   = '0;
               cap_in   = '0;
               ad_in    = IW'(2);
               res_status_in = STAT_BAD;
               res_value_in  = '0;
               res_used_in   = '0;
               unique case (req_func)
                  FUNC_ALLOC: begin
                     if (req_len == '0) res_status_in = STAT_EMPTY;
                  end
                  FUNC_FREE: begin
                     res_status_in = STAT_BAD;
                  end
                  FUNC_READ: begin
                     if (ci_live) begin
                        res_status_in = STAT_OK;
                        if (req_ci == IDX_W'(0)) begin
                           res_value_in = ENTRY_MEDIA_HI | ENTRY_W'(media_ff);
                        end else if (req_ci == IDX_W'(1)) begin
                           res_value_in = ENTRY_EOC;
                        end
                     end
                  end
                  default: begin
                     res_status_in = STAT_BAD;
                  end
               endcase
            end
         end

         // Count free capacity until it covers the length or the table ends.
         S_SCAN: begin
            if (ad_live) begin
               ad_in     = ad_ff + IW'(1);
               rd_vld_in = 1'b1;
            end
            if (scan_hit) cap_in = cap_ff + CAP_W'(bpc_eff);
            if (cap_ok) begin
               ad_in     = IW'(2);
               rd_vld_in = 1'b0;
               cnt_in    = '0;
               rem_in    = len_ff;
            end else if (scan_end) begin
               res_status_in = STAT_FULL;
               res_value_in  = '0;
               res_used_in   = '0;
            end
         end

         // Take free entries in order and link the one before to each.
         S_ALLOC: begin
            if (ad_live) begin
               ad_in     = ad_ff + IW'(1);
               rd_vld_in = !(scan_hit && take_last);
            end
            rd_idx_in = ad_ff[AW-1:0];
            if (scan_hit) begin
               if (cnt_ff == '0) begin
                  first_in = rd_idx_ff;
               end else begin
                  ram_we      = 1'b1;
                  ram_wr_addr = prev_ff;
                  ram_wdata   = ENTRY_W'(rd_idx_ff);
               end
               prev_in = rd_idx_ff;
               cnt_in  = cnt_ff + USED_W'(1);
               rem_in  = rem_ff - LEN_W'(bpc_eff);
            end
         end

         // Close the chain with the end-of-chain mark.
         S_LINK_END: begin
            ram_we        = 1'b1;
            ram_wr_addr   = prev_ff;
            ram_wdata     = ENTRY_EOC;
            res_status_in = STAT_OK;
            res_value_in  = ENTRY_W'(first_ff);
            res_used_in   = cnt_ff;
         end

         // Check the next link and fetch its entry.
         S_FREE_CHK: begin
            ram_rd_addr   = idx_ff[AW-1:0];
            res_value_in  = start_ff;
            res_used_in   = cnt_ff;
            res_status_in = free_end ? STAT_OK : STAT_BAD;
         end

         // Zero the entry and follow its link.
         S_FREE_WR: begin
            ram_we      = 1'b1;
            ram_wr_addr = idx_ff[AW-1:0];
            ram_wdata   = ENTRY_FREE;
            cnt_in      = cnt_ff + USED_W'(1);
            idx_in      = ram_rdata;
         end

         S_READ: begin
            res_status_in = STAT_OK;
            res_value_in  = ram_rdata;
            res_used_in   = '0;
         end

         // Hand the result to the output register once it is free.
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_used_in   = res_used_ff;
            end
         end

         default: begin
            rd_vld_in = 1'b0;
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      ct_in    = ct_ff;
      bpc_in   = bpc_ff;
      media_in = media_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_CLUSTER_TOTAL:     ct_in    = csr_wdata[CT_W-1:0];
            CSR_BYTES_PER_CLUSTER: bpc_in   = csr_wdata;
            CSR_MEDIA_TYPE:        media_in = csr_wdata[MEDIA_W-1:0];
            default:               ct_in    = ct_ff;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ad_ff        <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ct_ff        <= CT_RESET;
         bpc_ff       <= BPC_RESET;
         media_ff     <= MEDIA_RESET;
      end else begin
         state_ff     <= state_in;
         ad_ff        <= ad_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         ct_ff        <= ct_in;
         bpc_ff       <= bpc_in;
         media_ff     <= media_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      rem_ff        <= rem_in;
      cap_ff        <= cap_in;
      start_ff      <= start_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      rd_idx_ff     <= rd_idx_in;
      prev_ff       <= prev_in;
      first_ff      <= first_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_used_ff   <= res_used_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // Ports.
   assign req_tready = state_ff == S_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_used_ff, rsp_value_ff};

`ifndef NO_ASSERTIONS
   // The reserved entries are never written once the clearing pass is over.
   assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != S_CLEAR) |-> (ram_wr_addr >= AW'(2)))
      else $error("table write to a reserved entry");

   // A link always points forward to a higher entry.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC && ram_we) |-> (ram_wdata > ENTRY_W'(prev_ff)))
      else $error("allocation link does not point forward");

   // A freed entry is the one whose link was just fetched.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREE_WR) |-> (ram_wr_addr == $past(ram_rd_addr)))
      else $error("free wrote an entry other than the one read");

   // A response only appears out of the result hand-off state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response raised outside the hand-off state");
`endif

endmodule
